/* src/vision_target_median_qualifier_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the vision target median qualifier
// Implication and next-cycle checks, sampled on the rising clock edge,
// disabled while the active-low reset is held.
// ----------------------------------------------------------------------------
`ifndef VISION_TARGET_MEDIAN_QUALIFIER_UNIT_ASSERT_SVH
`define VISION_TARGET_MEDIAN_QUALIFIER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define VTMQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("vtmq: implication check failed");

// next-cycle implication
`define VTMQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("vtmq: next-cycle check failed");

`else

`define VTMQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define VTMQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* src/vtmq_pkg.sv */
// ----------------------------------------------------------------------------
// vtmq_pkg
// Shared types, constants and helpers of the vision target median qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package vtmq_pkg;

    localparam int WINDOW_LEN_DEF = 15;

    localparam logic [7:0]  HDR_VALID  = 8'hDD;
    localparam logic [7:0]  FOUND_MARK = 8'hAA;
    localparam logic [14:0] MAG_MASK   = 15'h7fff;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT   = 2'd1;

    localparam logic [7:0] FRAME_WINDOW_RST = 8'd10;
    localparam logic [7:0] MISS_LIMIT_RST   = 8'd10;
    localparam logic [7:0] COUNT_MAX        = 8'hFF;

    typedef logic signed [15:0] coord_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EVAL
    } ctrl_state_t;

    typedef struct packed {
        logic capture;   // latch incoming word
        logic update;    // shift windows and re-sort
        logic eval;      // close out the frame and load the result
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_hdr_ok;
        logic in_found;
        logic out_free;
    } ctrl_status_t;

    // sign-magnitude to two's complement; negative zero becomes zero
    function automatic coord_t sm_to_signed(input logic [15:0] w);
        logic [15:0] mag;
        mag = {1'b0, w[14:0] & MAG_MASK};
        return w[15] ? coord_t'(-mag) : coord_t'(mag);
    endfunction

endpackage

`default_nettype wire

/* src/vtmq_ctrl.sv */
// ----------------------------------------------------------------------------
// vtmq_ctrl
// Frame sequencer: accept a word (dropped on a bad header), re-sort the windows
// on a found frame, then close out the frame once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module vtmq_ctrl
    import vtmq_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire ctrl_status_t status,
    output ctrl_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // hold off the sender while reset is applied
                s_tready = aresetn;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    // drop frames with a bad header outright
                    if (!status.in_hdr_ok) begin
                        state_next = ST_IDLE;
                    end else if (status.in_found) begin
                        state_next = ST_UPDATE;
                    end else begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                // hold until the previous result has gone
                if (status.out_free) begin
                    cmd.eval   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/vtmq_datapath.sv */
// ----------------------------------------------------------------------------
// vtmq_datapath
// Sliding windows kept twice: in arrival order and as a sorted row of cells,
// plus frame counters, configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vision_target_median_qualifier_unit_assert.svh"

module vtmq_datapath
    import vtmq_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [7:0]            cfg_data,
    input  wire ctrl_cmd_t             cmd,
    output ctrl_status_t               status,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [OUT_USER_W-1:0]      m_tuser,
    output logic                       m_tlast
);

    localparam int MID = WINDOW_LEN / 2;

    typedef coord_t win_t [WINDOW_LEN];

    // remove old_v from a sorted row, then insert new_v; each cell decides alone
    function automatic win_t sorted_replace(input win_t s, input coord_t old_v,
                                            input coord_t new_v);
        win_t                  rem;
        win_t                  res;
        logic [WINDOW_LEN-1:0] le;
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            rem[i] = (s[i] >= old_v) ? s[i+1] : s[i];
        end
        rem[WINDOW_LEN-1] = s[WINDOW_LEN-1];
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            le[i] = (rem[i] <= new_v);
        end
        le[WINDOW_LEN-1] = 1'b0;
        res[0] = le[0] ? rem[0] : new_v;
        for (int i = 1; i < WINDOW_LEN; i++) begin
            res[i] = le[i] ? rem[i] : (le[i-1] ? new_v : rem[i-1]);
        end
        return res;
    endfunction

    logic [7:0] frame_window_reg, miss_limit_reg;
    logic [7:0] frame_count_reg, miss_count_reg;
    logic       untrusted_reg;
    coord_t     held_x_reg, held_y_reg;
    coord_t     new_x_reg, new_y_reg;
    logic       found_reg;
    win_t       fifo_x_reg, fifo_y_reg;
    win_t       sort_x_reg, sort_y_reg;
    win_t       sort_x_next, sort_y_next;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_USER_W-1:0] m_tuser_reg;
    logic                  m_tlast_reg;

    logic [7:0] frame_count_next, miss_count_next;
    logic       closed, clear_now, untrusted_next;
    coord_t     held_x_next, held_y_next;

    assign status.in_hdr_ok = (s_tdata[7:0] == HDR_VALID);
    assign status.in_found  = (s_tdata[15:8] == FOUND_MARK);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign sort_x_next = sorted_replace(sort_x_reg, fifo_x_reg[0], new_x_reg);
    assign sort_y_next = sorted_replace(sort_y_reg, fifo_y_reg[0], new_y_reg);

    always_comb begin
        frame_count_next = (frame_count_reg == COUNT_MAX) ? frame_count_reg
                                                          : frame_count_reg + 8'd1;
        miss_count_next  = (found_reg || miss_count_reg == COUNT_MAX) ? miss_count_reg
                                                                     : miss_count_reg + 8'd1;
        closed         = (frame_count_next >= frame_window_reg);
        clear_now      = closed && (miss_count_next >= miss_limit_reg);
        untrusted_next = closed ? clear_now : untrusted_reg;
        held_x_next    = found_reg ? sort_x_reg[MID] : held_x_reg;
        held_y_next    = found_reg ? sort_y_reg[MID] : held_y_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_window_reg <= FRAME_WINDOW_RST;
            miss_limit_reg   <= MISS_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FRAME_WINDOW: frame_window_reg <= cfg_data;
                CFG_MISS_LIMIT:   miss_limit_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // latch the incoming word
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            new_x_reg <= sm_to_signed(s_tdata[31:16]);
            new_y_reg <= sm_to_signed(s_tdata[47:32]);
            found_reg <= status.in_found;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= '0;
            miss_count_reg  <= '0;
            untrusted_reg   <= 1'b0;
            held_x_reg      <= '0;
            held_y_reg      <= '0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                fifo_x_reg[i] <= '0;
                fifo_y_reg[i] <= '0;
                sort_x_reg[i] <= '0;
                sort_y_reg[i] <= '0;
            end
        end else if (cmd.update) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                fifo_x_reg[i] <= fifo_x_reg[i+1];
                fifo_y_reg[i] <= fifo_y_reg[i+1];
            end
            fifo_x_reg[WINDOW_LEN-1] <= new_x_reg;
            fifo_y_reg[WINDOW_LEN-1] <= new_y_reg;
            sort_x_reg <= sort_x_next;
            sort_y_reg <= sort_y_next;
        end else if (cmd.eval) begin
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            untrusted_reg <= untrusted_next;
            if (closed) begin
                frame_count_reg <= '0;
                miss_count_reg  <= '0;
            end else begin
                frame_count_reg <= frame_count_next;
                miss_count_reg  <= miss_count_next;
            end
            // drop both windows; held positions stay
            if (clear_now) begin
                for (int i = 0; i < WINDOW_LEN; i++) begin
                    fifo_x_reg[i] <= '0;
                    fifo_y_reg[i] <= '0;
                    sort_x_reg[i] <= '0;
                    sort_y_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.eval) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            m_tdata_reg <= {held_y_next, held_x_next};
            m_tuser_reg <= {untrusted_next, found_reg};
            m_tlast_reg <= closed;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `VTMQ_ASSERT_IMP(a_sorted_mid, aclk, aresetn, 1'b1, (sort_x_reg[MID-1] <= sort_x_reg[MID]) && (sort_x_reg[MID] <= sort_x_reg[MID+1]))
    `VTMQ_ASSERT_NXT(a_clear_zero, aclk, aresetn, cmd.eval && clear_now, (sort_x_reg[MID] == 16'sd0) && (fifo_y_reg[WINDOW_LEN-1] == 16'sd0))
    `VTMQ_ASSERT_IMP(a_load_free, aclk, aresetn, cmd.eval, !m_tvalid_reg || m_tready)

endmodule

`default_nettype wire

/* src/vision_target_median_qualifier_unit.sv */
// ----------------------------------------------------------------------------
// vision_target_median_qualifier_unit
// Qualifies camera target frames and median-filters the reported position.
//
//   channel | dir | fields (lowest bit up)
//   s_      | in  | tdata: header_byte, found_byte, x_word, y_word
//   m_      | out | tdata: x_position, y_position; tuser: position_updated,
//           |     | untrusted; tlast: window_closed
//   cfg_    | in  | index 0 frame_window, index 1 miss_limit; ready out of reset
//
// A found frame steps through accept, sorted-cell update and close-out; a miss
// goes from accept to close-out; a bad header is dropped in the accept cycle.
// The sorted cell row removes the oldest entry and inserts the new one at once.
// Reset is synchronous and clears windows, counters and held positions.
// A stalled result holds the close-out step; a new word is taken meanwhile
// once the close-out has loaded the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vision_target_median_qualifier_unit
    import vtmq_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // header_byte[7:0], found_byte[15:8], x_word[31:16], y_word[47:32]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // x_position[15:0], y_position[31:16]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // position_updated[0], untrusted[1]
    output logic [OUT_USER_W-1:0]      m_tuser,
    output logic                       m_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [7:0]            cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = aresetn;

    vtmq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vtmq_datapath #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

/* sim/median_qualifier_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// median_qualifier_checker
// Watches the frame, result and register channels of the target qualifier.
// Keeps its own copy of the coordinate windows, counters and flags, works out
// each frame's result word and compares it field by field with what arrives.
// ----------------------------------------------------------------------------
module median_qualifier_checker
    import vtmq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic [OUT_USER_W-1:0] m_tuser,
    input  wire logic                 m_tlast,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    output int                        fail_count,
    output int                        open_results
);

    localparam int WLEN = WINDOW_LEN_DEF;

    typedef struct {
        coord_t x_pos;
        coord_t y_pos;
        logic   updated;
        logic   untrusted;
        logic   closed;
    } frame_result_t;

    coord_t        x_hist [WLEN];
    coord_t        y_hist [WLEN];
    logic [7:0]    frames_seen;
    logic [7:0]    misses_seen;
    logic [7:0]    frame_window;
    logic [7:0]    miss_limit;
    logic          untrusted_q;
    coord_t        held_x;
    coord_t        held_y;
    frame_result_t expected_results [$];

    initial begin
        fail_count   = 0;
        open_results = 0;
    end

    function automatic coord_t sm_decode(input logic [15:0] w);
        coord_t mag;
        mag = {1'b0, w[14:0]};
        return w[15] ? -mag : mag;
    endfunction

    function automatic coord_t window_median(input coord_t win [WLEN]);
        coord_t srt [WLEN];
        coord_t key;
        int     j;
        srt = win;
        for (int i = 1; i < WLEN; i++) begin
            key = srt[i];
            j = i - 1;
            while (j >= 0 && srt[j] > key) begin
                srt[j + 1] = srt[j];
                j--;
            end
            srt[j + 1] = key;
        end
        return srt[WLEN / 2];
    endfunction

    task automatic clear_history();
        for (int i = 0; i < WLEN; i++) begin
            x_hist[i] = '0;
            y_hist[i] = '0;
        end
    endtask

    task automatic qualify_frame(input logic [IN_DATA_W-1:0] w);
        frame_result_t r;
        if (w[7:0] != HDR_VALID) return;
        r.updated = 1'b0;
        r.closed  = 1'b0;
        if (frames_seen != COUNT_MAX) frames_seen++;
        if (w[15:8] == FOUND_MARK) begin
            // shift the oldest entry out, newest in at the top
            for (int i = 0; i < WLEN - 1; i++) begin
                x_hist[i] = x_hist[i + 1];
                y_hist[i] = y_hist[i + 1];
            end
            x_hist[WLEN - 1] = sm_decode(w[31:16]);
            y_hist[WLEN - 1] = sm_decode(w[47:32]);
            held_x = window_median(x_hist);
            held_y = window_median(y_hist);
            r.updated = 1'b1;
        end else if (misses_seen != COUNT_MAX) begin
            misses_seen++;
        end
        if (frames_seen >= frame_window) begin
            // held positions survive the clear
            if (misses_seen >= miss_limit) begin
                clear_history();
                untrusted_q = 1'b1;
            end else begin
                untrusted_q = 1'b0;
            end
            frames_seen = '0;
            misses_seen = '0;
            r.closed = 1'b1;
        end
        r.x_pos     = held_x;
        r.y_pos     = held_y;
        r.untrusted = untrusted_q;
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic signed [15:0] exp_v,
                               input logic signed [15:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic check_result();
        frame_result_t e;
        if (expected_results.size() == 0) begin
            $error("result word with no frame pending: tdata %h", m_tdata);
            fail_count++;
            return;
        end
        e = expected_results.pop_front();
        check_field("x_position", e.x_pos, m_tdata[15:0]);
        check_field("y_position", e.y_pos, m_tdata[31:16]);
        check_field("position_updated", e.updated, m_tuser[0]);
        check_field("untrusted", e.untrusted, m_tuser[1]);
        check_field("window_closed", e.closed, m_tlast);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_history();
            frames_seen  = '0;
            misses_seen  = '0;
            frame_window = FRAME_WINDOW_RST;
            miss_limit   = MISS_LIMIT_RST;
            untrusted_q  = 1'b0;
            held_x       = '0;
            held_y       = '0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRAME_WINDOW: frame_window = cfg_data;
                    CFG_MISS_LIMIT:   miss_limit = cfg_data;
                    default: ;
                endcase
            end
            // a word leaving now cannot belong to the frame arriving now
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) qualify_frame(s_tdata);
        end
        open_results = expected_results.size();
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives camera frames and register writes into the target qualifier with
// random gaps and result stalls; the checker beside the block judges each
// result word. Directed extremes first, then random phases over several
// window and miss-limit settings.
// ----------------------------------------------------------------------------
module tb;
    import vtmq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [7:0]            cfg_data  = '0;

    int fail_count;
    int open_results;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit stalls_on   = 1'b0;
    bit gaps_on     = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    vision_target_median_qualifier_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    median_qualifier_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .open_results (open_results)
    );

    // result-side back-pressure: mostly short stalls, now and then a long one
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (stalls_on && $urandom_range(0, 99) < 20) begin
            m_tready = 1'b0;
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                       : $urandom_range(10, 50);
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 5))
                0: return 16'h0000;
                1: return 16'h7FFF;
                2: return 16'h8000;
                3: return 16'hFFFF;
                4: return 16'h8001;
                default: return 16'h0001;
            endcase
        end
        // cluster near zero so the median sees ties and sign flips
        if (r < 4) return {1'($urandom_range(0, 1)), 15'($urandom_range(0, 20))};
        return 16'($urandom);
    endfunction

    task automatic send_frame(input logic [7:0] hdr, input logic [7:0] fnd,
                              input logic [15:0] xw, input logic [15:0] yw);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {yw, xw, fnd, hdr};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // hold the sender until every result is out, then let the block settle
    task automatic drain_results();
        s_tvalid = 1'b0;
        wait (open_results == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic run_phase(input logic [7:0] fw, input logic [7:0] ml,
                             input int frames, input int miss_pct);
        int          sent;
        logic [7:0]  hdr;
        logic [7:0]  fnd;
        drain_results();
        write_reg(CFG_FRAME_WINDOW, fw);
        write_reg(CFG_MISS_LIMIT, ml);
        sent = 0;
        while (sent < frames) begin
            if (sent % 40 == 0) begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            hdr = ($urandom_range(0, 99) < 8) ? 8'($urandom) : HDR_VALID;
            fnd = ($urandom_range(0, 99) < miss_pct) ? 8'($urandom) : FOUND_MARK;
            send_frame(hdr, fnd, pick_coord(), pick_coord());
            if (hdr == HDR_VALID) begin
                sent++;
                if (sent % 64 == 0) begin
                    s_tvalid = 1'b0;
                    wait (open_results == 0);
                    @(negedge aclk);
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: default settings, ten valid frames close one window
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_frame(8'h00, FOUND_MARK, 16'h1111, 16'h2222);
        send_frame(8'hFF, FOUND_MARK, 16'h3333, 16'h4444);
        send_frame(8'hDC, FOUND_MARK, 16'h5555, 16'h6666);
        send_frame(8'hDF, 8'h00, 16'hFFFF, 16'hFFFF);
        send_frame(HDR_VALID, FOUND_MARK, 16'h0000, 16'h0000);
        send_frame(HDR_VALID, FOUND_MARK, 16'h7FFF, 16'hFFFF);
        send_frame(HDR_VALID, FOUND_MARK, 16'h8000, 16'h8000);
        send_frame(HDR_VALID, FOUND_MARK, 16'hFFFF, 16'h7FFF);
        send_frame(HDR_VALID, 8'h00, 16'hAAAA, 16'h5555);
        send_frame(HDR_VALID, 8'hFF, 16'h1234, 16'h4321);
        send_frame(8'h5D, FOUND_MARK, 16'h0100, 16'h0200);
        send_frame(HDR_VALID, FOUND_MARK, 16'h8001, 16'h0001);
        send_frame(HDR_VALID, 8'hAB, 16'h0000, 16'hFFFF);
        send_frame(HDR_VALID, FOUND_MARK, 16'h1234, 16'h9234);
        send_frame(HDR_VALID, 8'h2A, 16'hFFFF, 16'h0000);
        send_frame(HDR_VALID, FOUND_MARK, 16'h0005, 16'h8005);
        send_frame(HDR_VALID, FOUND_MARK, 16'h8005, 16'h0005);
        send_frame(HDR_VALID, FOUND_MARK, 16'h0005, 16'h8005);

        // unused register slots must leave the settings alone
        drain_results();
        write_reg(CFG_SPARE_LO, 8'($urandom));
        write_reg(CFG_SPARE_HI, 8'($urandom));

        run_phase(8'd1, 8'd1, 80, 40);
        run_phase(8'd1, 8'd0, 40, 30);
        run_phase(8'd255, 8'd120, 270, 50);
        run_phase(8'd0, 8'd2, 40, 40);
        run_phase(8'd5, 8'd3, 120, 50);
        run_phase(8'd3, 8'd255, 60, 60);
        run_phase(8'($urandom_range(2, 20)), 8'($urandom_range(0, 12)), 150,
                  $urandom_range(20, 70));
        run_phase(8'd12, 8'd12, 100, 80);

        drain_results();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/vtmq_pkg.sv
src/vtmq_ctrl.sv
src/vtmq_datapath.sv
src/vision_target_median_qualifier_unit.sv
sim/median_qualifier_checker.sv
sim/tb.sv
